/* design/cfbm_pkg.sv */
`default_nettype none

package cfbm_pkg;

    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int ADDR_W    = 48;
    localparam int STRIDE_W  = 21;
    localparam int CC_W      = 7;
    localparam int CNT_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_STRIDE = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_FORMAT = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_A_POP,
        S_A_FILL,
        S_A_SLOT,
        S_A_CHECK,
        S_MUL,
        S_F_FILL,
        S_F_NEW,
        S_FORMAT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* design/chunked_free_buffer_manager.sv */
`default_nettype none

// Channel   Direction  Handshake                    Payload
// request   in         i_valid / o_stall            i_opcode, i_free_index
// result    out        o_valid / i_stall            o_status, o_given_index,
//                                                   o_given_address, o_listed_free
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item at a time; o_stall is high from acceptance until the result is loaded.
// Allocate forms the given address with a shift-add multiply on one 48-bit adder; format
// writes chunks * CHUNK_SLOTS slots, one slot write per cycle. The block goes back to idle
// after each result and only then accepts the next item.
// Reset (i_rst_n low, synchronous) empties the list and the held chunk; slot memory is
// not cleared. A result waiting in the output register holds the next item in its last cycle.

module chunked_free_buffer_manager #(
    parameter int MAX_BUFFERS = 1024,
    parameter int CHUNK_SLOTS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [cfbm_pkg::OP_W-1:0]            i_opcode,
    input  logic [$clog2(MAX_BUFFERS)-1:0]       i_free_index,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [cfbm_pkg::STATUS_W-1:0]        o_status,
    output logic [$clog2(MAX_BUFFERS)-1:0]       o_given_index,
    output logic [cfbm_pkg::ADDR_W-1:0]          o_given_address,
    output logic [cfbm_pkg::CNT_W-1:0]           o_listed_free,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [cfbm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cfbm_pkg::ADDR_W-1:0]          i_cfg_data
);
    import cfbm_pkg::*;

    localparam int IW         = $clog2(MAX_BUFFERS);
    localparam int VW         = IW + 1;
    localparam int SW         = $clog2(CHUNK_SLOTS);
    localparam int FW         = $clog2(CHUNK_SLOTS + 1);
    localparam int SA_DEPTH   = MAX_BUFFERS * CHUNK_SLOTS;
    localparam int SA_W       = $clog2(SA_DEPTH);
    localparam int FMT_CHUNKS = MAX_BUFFERS / CHUNK_SLOTS;

    localparam logic [VW-1:0]    NULL_MARK = '1;
    localparam logic [VW-1:0]    V_MAX     = VW'(MAX_BUFFERS);
    localparam logic [VW-1:0]    CS_V      = VW'(CHUNK_SLOTS);
    localparam logic [FW-1:0]    CS_F      = FW'(CHUNK_SLOTS);
    localparam logic [FW-1:0]    LAST_F    = FW'(CHUNK_SLOTS - 1);
    localparam logic [SW-1:0]    LAST_SLOT = SW'(CHUNK_SLOTS - 1);
    localparam logic [CNT_W-1:0] CS_CNT    = CNT_W'(CHUNK_SLOTS);

    function automatic logic [SA_W-1:0] slot_addr(input logic [IW-1:0] chunk,
                                                  input logic [SW-1:0] slot);
        return SA_W'(chunk) * SA_W'(CHUNK_SLOTS) + SA_W'(slot);
    endfunction

    // control and working registers
    t_state              r_state, n_state;
    t_opcode             r_op, n_op;
    logic [IW-1:0]       r_fidx, n_fidx;
    logic [IW-1:0]       r_held, n_held;
    logic                r_held_valid, n_held_valid;
    logic [VW-1:0]       r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [VW-1:0]       r_fmt, n_fmt;
    logic [CC_W-1:0]     r_nchunks, n_nchunks;
    logic [CC_W-1:0]     r_k, n_k;
    logic [IW-1:0]       r_ch, n_ch;
    logic [SW-1:0]       r_slot, n_slot;
    logic [VW-1:0]       r_v, n_v;
    t_status             r_status, n_status;
    logic [IW-1:0]       r_gidx, n_gidx;
    logic [IW-1:0]       r_midx, n_midx;
    logic [ADDR_W-1:0]   r_acc, n_acc;
    logic [ADDR_W-1:0]   r_mstride, n_mstride;

    // result register
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [IW-1:0]       r_out_gidx, n_out_gidx;
    logic [ADDR_W-1:0]   r_out_gaddr, n_out_gaddr;
    logic [CNT_W-1:0]    r_out_count, n_out_count;

    // configuration
    logic [CC_W-1:0]     r_chunk_count;
    logic [ADDR_W-1:0]   r_base;
    logic [STRIDE_W-1:0] r_stride;

    // slot and fill memories
    logic [VW-1:0]       r_slot_store [SA_DEPTH];
    logic [FW-1:0]       r_slot_fill  [MAX_BUFFERS];
    logic [VW-1:0]       r_ss_rdata;
    logic [FW-1:0]       r_sf_rdata;

    logic                ss_we;
    logic [SA_W-1:0]     ss_waddr, ss_raddr;
    logic [VW-1:0]       ss_wdata;
    logic                sf_we;
    logic [IW-1:0]       sf_waddr, sf_raddr;
    logic [FW-1:0]       sf_wdata;

    // shared helpers
    logic [FW-1:0]       fill_in;
    logic [IW-1:0]       take_chunk;
    logic [CNT_W:0]      cnt_sum;
    logic [CNT_W-1:0]    cnt_add, cnt_sub;
    logic [CC_W-1:0]     chunk_limit;

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_given_index   = r_out_gidx;
    assign o_given_address = r_out_gaddr;
    assign o_listed_free   = r_out_count;
    assign o_cfg_ready     = 1'b1;

    // a chunk taken from the list loses one fill count before the pop from it
    assign fill_in    = (r_state == S_A_POP && r_sf_rdata != '0) ? r_sf_rdata - FW'(1)
                                                                 : r_sf_rdata;
    assign take_chunk = (r_state == S_A_POP) ? r_head[IW-1:0] : r_held;
    assign cnt_sum    = {1'b0, r_count} + (CNT_W + 1)'(CHUNK_SLOTS);
    assign cnt_add    = (cnt_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt_sum[CNT_W-1:0];
    assign cnt_sub    = (r_count >= CS_CNT) ? r_count - CS_CNT : '0;
    assign chunk_limit = (int'(r_chunk_count) > FMT_CHUNKS) ? CC_W'(FMT_CHUNKS)
                                                            : r_chunk_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_START;
            end
            S_START: begin
                unique case (r_op)
                    OP_ALLOC: begin
                        if (r_held_valid)         n_state = S_A_FILL;
                        else if (r_head >= V_MAX) n_state = S_DONE;
                        else                      n_state = S_A_POP;
                    end
                    OP_FREE: begin
                        if (VW'(r_fidx) >= r_fmt) n_state = S_DONE;
                        else if (r_held_valid)    n_state = S_F_FILL;
                        else                      n_state = S_DONE;
                    end
                    OP_FORMAT: begin
                        n_state = (chunk_limit == '0) ? S_DONE : S_FORMAT;
                    end
                    OP_NOP: n_state = S_DONE;
                endcase
            end
            S_A_POP, S_A_FILL: begin
                n_state = (fill_in == '0) ? S_A_CHECK : S_A_SLOT;
            end
            S_A_SLOT:  n_state = S_A_CHECK;
            S_A_CHECK: n_state = (r_v < r_fmt) ? S_MUL : S_DONE;
            S_MUL: begin
                if (r_midx == '0) n_state = S_DONE;
            end
            S_F_FILL:  n_state = (r_sf_rdata == LAST_F) ? S_F_NEW : S_DONE;
            S_F_NEW:   n_state = S_DONE;
            S_FORMAT: begin
                if (r_slot == LAST_SLOT && r_k == r_nchunks - CC_W'(1)) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op         = r_op;
        n_fidx       = r_fidx;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_head       = r_head;
        n_count      = r_count;
        n_fmt        = r_fmt;
        n_nchunks    = r_nchunks;
        n_k          = r_k;
        n_ch         = r_ch;
        n_slot       = r_slot;
        n_v          = r_v;
        n_status     = r_status;
        n_gidx       = r_gidx;
        n_midx       = r_midx;
        n_acc        = r_acc;
        n_mstride    = r_mstride;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_gidx   = r_out_gidx;
        n_out_gaddr  = r_out_gaddr;
        n_out_count  = r_out_count;
        ss_we        = 1'b0;
        ss_waddr     = '0;
        ss_wdata     = '0;
        ss_raddr     = '0;
        sf_we        = 1'b0;
        sf_waddr     = '0;
        sf_wdata     = '0;
        sf_raddr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op   = t_opcode'(i_opcode);
                    n_fidx = i_free_index;
                end
            end
            S_START: begin
                n_status = STAT_OK;
                n_gidx   = '0;
                n_acc    = '0;
                unique case (r_op)
                    OP_ALLOC: begin
                        if (r_held_valid) begin
                            sf_raddr = r_held;
                        end else if (r_head >= V_MAX) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            ss_raddr = slot_addr(r_head[IW-1:0], LAST_SLOT);
                            sf_raddr = r_head[IW-1:0];
                        end
                    end
                    OP_FREE: begin
                        if (VW'(r_fidx) >= r_fmt) begin
                            n_status = STAT_BAD_INDEX;
                        end else if (r_held_valid) begin
                            sf_raddr = r_held;
                        end else begin
                            n_held       = r_fidx;
                            n_held_valid = 1'b1;
                            sf_we        = 1'b1;
                            sf_waddr     = r_fidx;
                        end
                    end
                    OP_FORMAT: begin
                        n_head       = NULL_MARK;
                        n_count      = '0;
                        n_held       = '0;
                        n_held_valid = 1'b0;
                        n_nchunks    = chunk_limit;
                        n_k          = '0;
                        n_ch         = '0;
                        n_slot       = '0;
                        if (chunk_limit == '0) n_fmt = '0;
                    end
                    OP_NOP: ;
                endcase
            end
            S_A_POP, S_A_FILL: begin
                if (r_state == S_A_POP) begin
                    // unlink the chunk; a broken link ends the list
                    n_head  = (r_ss_rdata < V_MAX) ? r_ss_rdata : NULL_MARK;
                    n_count = cnt_sub;
                end
                n_held   = take_chunk;
                sf_we    = 1'b1;
                sf_waddr = take_chunk;
                if (fill_in == '0) begin
                    // empty chunk hands out itself
                    n_v          = VW'(take_chunk);
                    n_held_valid = 1'b0;
                end else begin
                    sf_wdata     = fill_in - FW'(1);
                    ss_raddr     = slot_addr(take_chunk, SW'(fill_in - FW'(1)));
                    n_held_valid = 1'b1;
                end
            end
            S_A_SLOT: begin
                n_v = r_ss_rdata;
            end
            S_A_CHECK: begin
                if (r_v < r_fmt) begin
                    n_gidx    = r_v[IW-1:0];
                    n_midx    = r_v[IW-1:0];
                    n_acc     = r_base;
                    n_mstride = ADDR_W'(r_stride);
                end else begin
                    n_status = STAT_EMPTY;
                end
            end
            S_MUL: begin
                // shift-add: one multiplier bit per cycle, stop at the last set bit
                if (r_midx != '0) begin
                    if (r_midx[0]) n_acc = r_acc + r_mstride;
                    n_mstride = r_mstride << 1;
                    n_midx    = r_midx >> 1;
                end
            end
            S_F_FILL: begin
                if (r_sf_rdata == LAST_F) begin
                    // held chunk full: link it onto the list
                    ss_we        = 1'b1;
                    ss_waddr     = slot_addr(r_held, LAST_SLOT);
                    ss_wdata     = r_head;
                    sf_we        = 1'b1;
                    sf_waddr     = r_held;
                    sf_wdata     = CS_F;
                    n_head       = VW'(r_held);
                    n_count      = cnt_add;
                    n_held_valid = 1'b0;
                end else if (r_sf_rdata < CS_F) begin
                    ss_we    = 1'b1;
                    ss_waddr = slot_addr(r_held, SW'(r_sf_rdata));
                    ss_wdata = VW'(r_fidx);
                    sf_we    = 1'b1;
                    sf_waddr = r_held;
                    sf_wdata = r_sf_rdata + FW'(1);
                end
            end
            S_F_NEW: begin
                n_held       = r_fidx;
                n_held_valid = 1'b1;
                sf_we        = 1'b1;
                sf_waddr     = r_fidx;
            end
            S_FORMAT: begin
                ss_we    = 1'b1;
                ss_waddr = slot_addr(r_ch, r_slot);
                if (r_slot != LAST_SLOT) begin
                    ss_wdata = VW'(r_ch) + VW'(r_slot) + VW'(1);
                    n_slot   = r_slot + SW'(1);
                end else begin
                    ss_wdata = r_head;
                    sf_we    = 1'b1;
                    sf_waddr = r_ch;
                    sf_wdata = CS_F;
                    n_head   = VW'(r_ch);
                    n_count  = cnt_add;
                    n_slot   = '0;
                    n_ch     = r_ch + IW'(CHUNK_SLOTS);
                    n_k      = r_k + CC_W'(1);
                    if (r_k == r_nchunks - CC_W'(1)) n_fmt = VW'(r_ch) + CS_V;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_gidx   = r_gidx;
                    n_out_gaddr  = r_acc;
                    n_out_count  = r_count;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_held        <= '0;
            r_held_valid  <= 1'b0;
            r_head        <= NULL_MARK;
            r_count       <= '0;
            r_fmt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_held        <= n_held;
            r_held_valid  <= n_held_valid;
            r_head        <= n_head;
            r_count       <= n_count;
            r_fmt         <= n_fmt;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_fidx       <= n_fidx;
        r_nchunks    <= n_nchunks;
        r_k          <= n_k;
        r_ch         <= n_ch;
        r_slot       <= n_slot;
        r_v          <= n_v;
        r_status     <= n_status;
        r_gidx       <= n_gidx;
        r_midx       <= n_midx;
        r_acc        <= n_acc;
        r_mstride    <= n_mstride;
        r_out_status <= n_out_status;
        r_out_gidx   <= n_out_gidx;
        r_out_gaddr  <= n_out_gaddr;
        r_out_count  <= n_out_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_count <= '0;
            r_base        <= '0;
            r_stride      <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHUNK_COUNT:   r_chunk_count <= i_cfg_data[CC_W-1:0];
                CFG_BUFFER_BASE:   r_base        <= i_cfg_data;
                CFG_BUFFER_STRIDE: r_stride      <= i_cfg_data[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (ss_we) r_slot_store[ss_waddr] <= ss_wdata;
        r_ss_rdata <= r_slot_store[ss_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sf_we) r_slot_fill[sf_waddr] <= sf_wdata;
        r_sf_rdata <= r_slot_fill[sf_raddr];
    end

endmodule

`default_nettype wire
